// File: sv/message_packet_segmenter_assert.svh
// Assertion macros shared by the segmenter RTL.
`ifndef MESSAGE_PACKET_SEGMENTER_ASSERT_SVH
`define MESSAGE_PACKET_SEGMENTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("segmenter assertion failed");

// Next-cycle implication, checked outside reset.
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("segmenter assertion failed");

`endif

// File: sv/mps_pkg.sv
// Types and constants of the message packet segmenter.
`timescale 1ns / 1ps

package mps_pkg;

    localparam logic       ACT_START  = 1'b0;
    localparam logic       ACT_DATA   = 1'b1;

    localparam logic [7:0] TYPE_START = 8'h0A;
    localparam logic [7:0] TYPE_CONT  = 8'h0B;
    localparam logic [7:0] TYPE_END   = 8'h0C;

    localparam logic [1:0] IDX_HTYPE  = 2'd0;
    localparam logic [1:0] IDX_HLEN   = 2'd1;
    localparam logic [1:0] IDX_LAST   = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       end_of_item;
        logic       end_of_message;
        logic [4:0] packet_count;
    } t_result;

    // Results of one input transaction, entries first..IDX_LAST are valid.
    typedef struct packed {
        logic        load;
        logic [1:0]  first;
        t_result [2:0] ent;
    } t_group;

endpackage

// File: sv/mps_if.sv
// Valid/ready channel interfaces for segmenter input and output transactions.
`timescale 1ns / 1ps

interface mps_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] msg_length;
    logic [7:0]  data_byte;

    modport source (output valid, output action, output msg_length, output data_byte,
                    input ready);
    modport sink   (input valid, input action, input msg_length, input data_byte,
                    output ready);
endinterface

interface mps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_header;
    logic       end_of_item;
    logic       end_of_message;
    logic [4:0] packet_count;

    modport source (output valid, output out_byte, output is_header, output end_of_item,
                    output end_of_message, output packet_count, input ready);
    modport sink   (input valid, input out_byte, input is_header, input end_of_item,
                    input end_of_message, input packet_count, output ready);
endinterface

// File: sv/message_packet_segmenter.sv
// Message packet segmenter top level.
// Latency: results of an input transaction appear the cycle after it is accepted.
// Throughput: one result per cycle while o_out.ready is high; a data byte opening a packet
// gives three results, other data bytes one, held off by the single result group register.
// Reset: i_rst_n synchronous active low, closes any open message and drops pending results.
`timescale 1ns / 1ps

module message_packet_segmenter #(
    parameter int PAYLOAD_PER_PACKET = 22,
    parameter int MAX_PACKETS        = 20
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mps_in_if.sink   i_in,
    mps_out_if.source o_out
);
    import mps_pkg::*;

    t_group w_grp;
    logic   w_can_load;
    logic   w_fire;

    assign i_in.ready = w_can_load;
    assign w_fire     = i_in.valid && w_can_load;

    mps_core #(
        .PAYLOAD_PER_PACKET(PAYLOAD_PER_PACKET),
        .MAX_PACKETS       (MAX_PACKETS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_action    (i_in.action),
        .i_msg_length(i_in.msg_length),
        .i_data_byte (i_in.data_byte),
        .o_grp       (w_grp)
    );

    mps_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_grp     (w_grp),
        .o_can_load(w_can_load),
        .o_out     (o_out)
    );

endmodule

// File: sv/mps_core.sv
// Segmentation state and per-transaction result group computation.
`timescale 1ns / 1ps

module mps_core #(
    parameter int PAYLOAD_PER_PACKET = 22,
    parameter int MAX_PACKETS        = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_action,
    input  logic [15:0]     i_msg_length,
    input  logic [7:0]      i_data_byte,
    output mps_pkg::t_group o_grp
);
    import mps_pkg::*;
    `include "message_packet_segmenter_assert.svh"

    localparam int LIMIT = PAYLOAD_PER_PACKET * MAX_PACKETS;
    localparam int LW    = $clog2(LIMIT + 1);
    localparam int PW    = (PAYLOAD_PER_PACKET > 1) ? $clog2(PAYLOAD_PER_PACKET) : 1;
    localparam int PW1   = PW + 1;
    localparam int IW    = $clog2(MAX_PACKETS + 1);

    logic [LW-1:0] r_bytes_left, n_bytes_left;
    logic [PW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_open, n_open;

    logic [15:0]   len_c;
    logic          hdr;
    logic          last_pkt;
    logic [PW1-1:0] pos_inc;
    logic [IW-1:0] idx_inc;
    logic [LW-1:0] bl_dec;

    assign len_c    = (i_msg_length > 16'(LIMIT)) ? 16'(LIMIT) : i_msg_length;
    assign hdr      = (r_pos == '0);
    assign last_pkt = (r_bytes_left <= LW'(PAYLOAD_PER_PACKET));
    assign pos_inc  = {1'b0, r_pos} + PW1'(1);
    assign idx_inc  = r_idx + IW'(hdr);
    assign bl_dec   = r_bytes_left - LW'(1);

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_open       = r_open;
        o_grp        = '0;
        o_grp.first  = IDX_LAST;
        if (i_fire) begin
            if (i_action == ACT_START) begin
                n_pos        = '0;
                n_idx        = '0;
                n_bytes_left = LW'(len_c);
                n_open       = (len_c != 16'd0);
                if (len_c == 16'd0) begin
                    o_grp.load = 1'b1;
                    o_grp.first = IDX_HLEN;
                    o_grp.ent[IDX_HLEN].out_byte       = TYPE_END;
                    o_grp.ent[IDX_HLEN].is_header      = 1'b1;
                    o_grp.ent[IDX_LAST].is_header      = 1'b1;
                    o_grp.ent[IDX_LAST].end_of_item    = 1'b1;
                    o_grp.ent[IDX_LAST].end_of_message = 1'b1;
                    o_grp.ent[IDX_LAST].packet_count   = 5'd1;
                end
            end else if (r_open && (r_bytes_left != '0)) begin
                o_grp.load = 1'b1;
                if (hdr) begin
                    o_grp.first = IDX_HTYPE;
                    o_grp.ent[IDX_HTYPE].is_header = 1'b1;
                    o_grp.ent[IDX_HLEN].is_header  = 1'b1;
                    if (last_pkt) begin
                        o_grp.ent[IDX_HTYPE].out_byte = TYPE_END;
                        o_grp.ent[IDX_HLEN].out_byte  = 8'(r_bytes_left);
                    end else begin
                        o_grp.ent[IDX_HTYPE].out_byte = (r_idx == '0) ? TYPE_START : TYPE_CONT;
                        o_grp.ent[IDX_HLEN].out_byte  = 8'(PAYLOAD_PER_PACKET);
                    end
                end
                n_idx        = idx_inc;
                n_bytes_left = bl_dec;
                n_pos        = (pos_inc >= PW1'(PAYLOAD_PER_PACKET)) ? '0 : PW'(pos_inc);
                o_grp.ent[IDX_LAST].out_byte    = i_data_byte;
                o_grp.ent[IDX_LAST].end_of_item = 1'b1;
                if (bl_dec == '0) begin
                    o_grp.ent[IDX_LAST].end_of_message = 1'b1;
                    o_grp.ent[IDX_LAST].packet_count   = 5'(idx_inc);
                    n_open = 1'b0;
                    n_pos  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_pos        <= '0;
            r_idx        <= '0;
            r_open       <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_pos        <= n_pos;
            r_idx        <= n_idx;
            r_open       <= n_open;
        end
    end

    // an open message always has bytes outstanding
    `MPS_ASSERT_NOW(a_open_has_bytes, i_clk, i_rst_n, r_open, r_bytes_left != '0)

endmodule

// File: sv/mps_serializer.sv
// Result group register, emits one result per output transaction.
`timescale 1ns / 1ps

module mps_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mps_pkg::t_group i_grp,
    output logic            o_can_load,
    mps_out_if.source       o_out
);
    import mps_pkg::*;
    `include "message_packet_segmenter_assert.svh"

    logic          r_busy, n_busy;
    logic [1:0]    r_idx, n_idx;
    t_result [2:0] r_ent;
    t_result       cur;
    logic          pop;

    assign cur        = r_ent[r_idx];
    assign pop        = r_busy && o_out.ready;
    assign o_can_load = !r_busy || (o_out.ready && (r_idx == IDX_LAST));

    assign o_out.valid          = r_busy;
    assign o_out.out_byte       = cur.out_byte;
    assign o_out.is_header      = cur.is_header;
    assign o_out.end_of_item    = cur.end_of_item;
    assign o_out.end_of_message = cur.end_of_message;
    assign o_out.packet_count   = cur.packet_count;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_grp.load) begin
            n_busy = 1'b1;
            n_idx  = i_grp.first;
        end else if (pop) begin
            if (r_idx == IDX_LAST) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= IDX_LAST;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp.load) begin
            r_ent <= i_grp.ent;
        end
    end

    // payload bytes are always the last result of a transaction
    `MPS_ASSERT_NOW(a_data_ends_item, i_clk, i_rst_n, r_busy && !cur.is_header,
        cur.end_of_item)
    `MPS_ASSERT_NOW(a_count_on_eom, i_clk, i_rst_n, r_busy && (cur.packet_count != 5'd0),
        cur.end_of_message && cur.end_of_item)
    // a stalled group does not advance
    `MPS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_busy && !o_out.ready,
        r_busy && $stable(r_idx))

endmodule
